/* hw/rtl/ils_pkg.sv */
package ils_pkg;

	// Sequencer states of the sorter
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_PUT,
		ST_ORD,
		ST_OLD,
		ST_OUT
	} ils_state_t;

endpackage

/* hw/rtl/integer_list_sorter_top.sv */
// Sorted-list engine: keeps signed words in sorted order as they arrive, emits them after the word marked final.
// Load: a word into an empty store is written at once, one into a full store is dropped;
//   else entries are read and compared (ST_RD, ST_CMP), then it is put; in_stall is high meanwhile.
// Emit: each sorted word takes a memory read, a register and a handshake (ST_ORD, ST_OLD, ST_OUT).
// Reset (arst_n low, asynchronous) clears the sequencer, the count and the drop flag;
//   the item store is not cleared and needs no clearing pass.
module integer_list_sorter_top #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          is_final,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] sorted_value,
	output logic                          end_of_list,
	output logic                          overflow
);
	import ils_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W = $clog2(MAX_ITEMS);

	ils_state_t state_q, state_d;

	// Store of held words; kept in ascending order at all times
	logic signed [VALUE_WIDTH-1:0] mem [MAX_ITEMS];
	logic signed [VALUE_WIDTH-1:0] rdata_q;

	logic [CNT_W-1:0]              count_q;
	logic                          drop_q;
	logic [IDX_W-1:0]              j_q;      // hole position during insertion
	logic [IDX_W-1:0]              k_q;      // emit position
	logic signed [VALUE_WIDTH-1:0] new_q;    // word being inserted
	logic                          fin_q;    // word being inserted ends the list
	logic signed [VALUE_WIDTH-1:0] sorted_q;
	logic                          eol_q;
	logic                          ovf_q;

	logic                          in_acc;
	logic                          out_acc;
	logic                          full;
	logic                          greater;  // the shared compare unit
	logic                          last_k;
	logic                          we;
	logic [IDX_W-1:0]              waddr;
	logic signed [VALUE_WIDTH-1:0] wdata;
	logic [IDX_W-1:0]              raddr;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign full    = (count_q == CNT_W'(MAX_ITEMS));
	assign greater = (rdata_q > new_q);
	assign last_k  = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = (state_q == ST_OUT);
	assign sorted_value = sorted_q;
	assign end_of_list  = eol_q;
	assign overflow     = ovf_q;

	// Read the entry left of the hole while inserting, else the emit position
	assign raddr = (state_q == ST_RD) ? (j_q - IDX_W'(1)) : k_q;

	// Next state and store write control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = j_q;
		wdata   = new_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (full) begin
						// drop the word; a final word still ends the list
						if (is_final) state_d = ST_ORD;
					end else if (count_q == '0) begin
						we    = 1'b1;
						waddr = '0;
						wdata = value;
						if (is_final) state_d = ST_ORD;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (greater) begin
					// shift the larger entry right into the hole
					we    = 1'b1;
					wdata = rdata_q;
					state_d = (j_q == IDX_W'(1)) ? ST_PUT : ST_RD;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				we      = 1'b1;
				state_d = fin_q ? ST_ORD : ST_IDLE;
			end
			ST_ORD: begin
				state_d = ST_OLD;
			end
			ST_OLD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_acc) state_d = last_k ? ST_IDLE : ST_ORD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			j_q     <= '0;
			k_q     <= '0;
			fin_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (in_acc) begin
						fin_q <= is_final;
						j_q   <= count_q[IDX_W-1:0];
						if (full) begin
							drop_q <= 1'b1;
						end else if (count_q == '0) begin
							count_q <= CNT_W'(1);
						end
					end
				end
				ST_CMP: begin
					if (greater) j_q <= j_q - IDX_W'(1);
				end
				ST_PUT: begin
					count_q <= count_q + CNT_W'(1);
				end
				ST_OUT: begin
					if (out_acc) begin
						if (last_k) begin
							// list delivered: start the next one empty
							count_q <= '0;
							drop_q  <= 1'b0;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) new_q <= value;
		if (state_q == ST_OLD) begin
			sorted_q <= rdata_q;
			eol_q    <= last_k;
			ovf_q    <= drop_q;
		end
	end

	// Item store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count exceeds capacity");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("emitting from an empty store");

	a_cmp_hole: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (j_q != '0))
		else $error("insertion compare with hole at entry zero");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> drop_q)
		else $error("word taken while full without drop flag");

	a_list_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && end_of_list) |=> (count_q == '0 && !drop_q && state_q == ST_IDLE))
		else $error("list state not cleared after last word");

endmodule
